[sv/sts_pkg.sv]
// shared types, constants and the saturating add for the taylor-series sine block
// no dependencies
package sts_pkg;

   localparam int AngleW    = 32;
   localparam int CountW    = 5;
   localparam int TargetW   = 6;
   localparam int ThreshW   = 29;
   localparam int RecipW    = 30;
   localparam int CsrIndexW = 2;
   localparam int MaxTerms  = 16;

   localparam logic [CountW-1:0]  TermCountReset = CountW'(10);
   localparam logic [ThreshW-1:0] ThresholdReset = ThreshW'(26844);

   typedef enum logic [CsrIndexW-1:0] {
      CSR_STOP_MODE = 2'd0,
      CSR_TERM_COUNT = 2'd1,
      CSR_THRESHOLD = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic               stop_mode;
      logic [TargetW-1:0] target;
      logic [ThreshW-1:0] threshold;
   } cfg_type;

   typedef struct packed {
      logic                     valid;
      logic                     done;
      logic                     pending;
      logic                     neg;
      logic [AngleW-1:0]        mag;
      logic signed [AngleW-1:0] sum;
      logic [AngleW-1:0]        sq;
      logic [CountW-1:0]        n;
   } cell_data_type;

   function automatic logic signed [AngleW-1:0] sat_add(
      input logic signed [AngleW-1:0] sum,
      input logic [AngleW-1:0]        mag,
      input logic                     neg
   );
      logic signed [AngleW+1:0] term;
      logic signed [AngleW+1:0] wide;
      term = signed'({2'b00, mag});
      if (neg) begin
         term = -term;
      end
      wide = signed'({{2{sum[AngleW-1]}}, sum}) + term;
      if (wide > 34'sd2147483647) begin
         sat_add = 32'sh7FFFFFFF;
      end else if (wide < -34'sd2147483648) begin
         sat_add = 32'sh80000000;
      end else begin
         sat_add = signed'(wide[AngleW-1:0]);
      end
   endfunction

endpackage

[sv/sts_front.sv]
// front stage: angle magnitude and rounded square for the term chain
// depends on sts_pkg
module sts_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic signed [sts_pkg::AngleW-1:0] angle,
   output sts_pkg::cell_data_type        data_out
);

   logic                              valid1_ff;
   logic signed [sts_pkg::AngleW-1:0] x1_ff;
   logic [sts_pkg::AngleW-1:0]        mag1_ff;
   logic                              neg1_ff;
   logic [2*sts_pkg::AngleW-1:0]      prod1_ff;

   logic [sts_pkg::AngleW-1:0]        mag1_in;
   logic [2*sts_pkg::AngleW-1:0]      prod1_in;
   logic [2*sts_pkg::AngleW-1:0]      rnd;
   sts_pkg::cell_data_type            data_in;
   sts_pkg::cell_data_type            data_ff;

   always_comb begin
      mag1_in  = angle[sts_pkg::AngleW-1] ? sts_pkg::AngleW'(-angle) : unsigned'(angle);
      prod1_in = 64'(mag1_in) * 64'(mag1_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else if (advance) begin
         valid1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x1_ff    <= angle;
         mag1_ff  <= mag1_in;
         neg1_ff  <= angle[sts_pkg::AngleW-1];
         prod1_ff <= prod1_in;
      end
   end

   // x*x rounded to q6.26, saturated
   always_comb begin
      rnd = (prod1_ff + 64'h20000000) >> 30;
      data_in.valid   = valid1_ff;
      data_in.done    = 1'b0;
      data_in.pending = 1'b0;
      data_in.neg     = neg1_ff;
      data_in.mag     = mag1_ff;
      data_in.sum     = x1_ff;
      data_in.n       = '0;
      data_in.sq      = (rnd > 64'hFFFFFFFF) ? 32'hFFFFFFFF : rnd[sts_pkg::AngleW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else if (advance) begin
         data_ff <= data_in;
      end
   end

   assign data_out = data_ff;

endmodule

[sv/sts_term_cell.sv]
// one series term cell: sum update, stop test, next-term magnitude in four stages
// depends on sts_pkg
module sts_term_cell #(
   parameter int CELL_INDEX = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  sts_pkg::cfg_type       cfg,
   input  sts_pkg::cell_data_type data_in,
   output sts_pkg::cell_data_type data_out
);

   localparam logic [63:0] Denom     = 64'(4 * CELL_INDEX * CELL_INDEX + 2 * CELL_INDEX);
   localparam logic [63:0] RecipFull = ((64'd1 << 32) + Denom / 2) / Denom;
   localparam logic [sts_pkg::RecipW-1:0] Recip = sts_pkg::RecipW'(RecipFull);

   sts_pkg::cell_data_type d1_in, d1_ff, d2_ff, d3_ff, out_in, out_ff;
   logic        stop;
   logic        act1_in, act1_ff, act2_ff, act3_ff;
   logic [63:0] prod1_in, prod1_ff;
   logic [36:0] rnd2_in, rnd2_ff;
   logic [62:0] lo3_in, lo3_ff;
   logic [34:0] hi3_in, hi3_ff;
   logic [35:0] res;
   logic [62:0] lo_rnd;

   // stage 1: add pending term, stop test, mag * x^2
   always_comb begin
      stop = cfg.stop_mode ? (data_in.mag < 32'(cfg.threshold))
                           : (6'(data_in.n) >= cfg.target);
      act1_in = data_in.valid && !data_in.done && !stop;
      d1_in = data_in;
      d1_in.done = data_in.done || stop;
      d1_in.pending = 1'b0;
      if (data_in.pending) begin
         d1_in.sum = sts_pkg::sat_add(data_in.sum, data_in.mag, data_in.neg);
      end
      prod1_in = 64'(data_in.mag) * 64'(data_in.sq);
   end

   // stage 2: round product to q28
   assign rnd2_in = 37'((prod1_ff + 64'h2000000) >> 26);

   // stage 3: times reciprocal, split high and low
   always_comb begin
      lo3_in = 63'(rnd2_ff[31:0]) * 63'(Recip);
      hi3_in = 35'(rnd2_ff[36:32]) * 35'(Recip);
   end

   // stage 4: recombine, round, saturate, flip sign
   always_comb begin
      lo_rnd = (lo3_ff + 63'h80000000) >> 32;
      res    = 36'(hi3_ff) + 36'(lo_rnd);
      out_in = d3_ff;
      if (act3_ff) begin
         out_in.mag     = (res > 36'h7FFFFFFF) ? 32'h7FFFFFFF : res[31:0];
         out_in.neg     = !d3_ff.neg;
         out_in.n       = d3_ff.n + 5'd1;
         out_in.pending = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff.valid  <= 1'b0;
         d2_ff.valid  <= 1'b0;
         d3_ff.valid  <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (advance) begin
         d1_ff  <= d1_in;
         d2_ff  <= d1_ff;
         d3_ff  <= d2_ff;
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         act1_ff  <= act1_in;
         act2_ff  <= act1_ff;
         act3_ff  <= act2_ff;
         prod1_ff <= prod1_in;
         rnd2_ff  <= rnd2_in;
         lo3_ff   <= lo3_in;
         hi3_ff   <= hi3_in;
      end
   end

   assign data_out = out_ff;

   assert property (@(posedge clock) disable iff (reset)
      out_ff.valid && out_ff.pending |-> out_ff.n == 5'(CELL_INDEX))
      else $error("term cell count mismatch on new term");

   assert property (@(posedge clock) disable iff (reset)
      out_ff.valid && !out_ff.done |-> out_ff.pending)
      else $error("running item left cell without a term");

   assert property (@(posedge clock) disable iff (reset)
      out_ff.valid && out_ff.pending |-> out_ff.mag <= 32'h7FFFFFFF)
      else $error("term magnitude not saturated");

endmodule

[sv/sine_taylor_series.sv]
// top level: config registers, front stage, chain of term cells, result register
// depends on sts_pkg, sts_front, sts_term_cell
// throughput: one item per cycle unless rsp_stall holds the chain
// the chain has MAX_TERMS cells of four stages each
// rsp_stall with a held result freezes the whole chain and raises req_stall
// reset: synchronous, clears all valid bits and loads config defaults
module sine_taylor_series #(
   parameter int MAX_TERMS = sts_pkg::MaxTerms
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [sts_pkg::AngleW-1:0]   req_angle,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [sts_pkg::AngleW-1:0]   rsp_sine_sum,
   output logic [sts_pkg::CountW-1:0]          rsp_terms_added,
   output logic                                rsp_limit_reached,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sts_pkg::CsrIndexW-1:0]       csr_index,
   input  logic [sts_pkg::ThreshW-1:0]         csr_data
);

   logic                              stop_mode_ff;
   logic [sts_pkg::CountW-1:0]        term_count_ff;
   logic [sts_pkg::ThreshW-1:0]       threshold_ff;
   sts_pkg::cfg_type                  cfg;
   logic                              advance;
   sts_pkg::cell_data_type            chain [MAX_TERMS+1];
   sts_pkg::cell_data_type            last;

   logic                              rsp_valid_ff;
   logic signed [sts_pkg::AngleW-1:0] rsp_sum_ff, rsp_sum_in;
   logic [sts_pkg::CountW-1:0]        rsp_terms_ff;
   logic                              rsp_limit_ff, rsp_limit_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_mode_ff  <= 1'b0;
         term_count_ff <= sts_pkg::TermCountReset;
         threshold_ff  <= sts_pkg::ThresholdReset;
      end else if (csr_valid && csr_ready) begin
         case (sts_pkg::csr_index_type'(csr_index))
            sts_pkg::CSR_STOP_MODE: begin
               stop_mode_ff <= csr_data[0];
            end
            sts_pkg::CSR_TERM_COUNT: begin
               term_count_ff <= csr_data[sts_pkg::CountW-1:0];
            end
            sts_pkg::CSR_THRESHOLD: begin
               threshold_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.stop_mode = stop_mode_ff;
      cfg.threshold = threshold_ff;
      cfg.target = ({1'b0, term_count_ff} > sts_pkg::TargetW'(MAX_TERMS))
                   ? sts_pkg::TargetW'(MAX_TERMS) : {1'b0, term_count_ff};
   end

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   sts_front u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_valid),
      .angle    (req_angle),
      .data_out (chain[0])
   );

   for (genvar k = 0; k < MAX_TERMS; k++) begin : g_term
      sts_term_cell #(
         .CELL_INDEX (k + 1)
      ) u_term (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cfg      (cfg),
         .data_in  (chain[k]),
         .data_out (chain[k+1])
      );
   end

   // last pending term and cap check
   always_comb begin
      last = chain[MAX_TERMS];
      rsp_sum_in = last.pending ? sts_pkg::sat_add(last.sum, last.mag, last.neg) : last.sum;
      rsp_limit_in = cfg.stop_mode && !last.done && (last.mag >= 32'(cfg.threshold));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= last.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_sum_ff   <= rsp_sum_in;
         rsp_terms_ff <= last.n;
         rsp_limit_ff <= rsp_limit_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sine_sum      = rsp_sum_ff;
   assign rsp_terms_added   = rsp_terms_ff;
   assign rsp_limit_reached = rsp_limit_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_limit_ff |-> rsp_terms_ff == sts_pkg::CountW'(MAX_TERMS))
      else $error("cap flag without full term count");

   assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid after reset");

endmodule
